>>> rtl/core/assert_macros.svh
// Assertion macros included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on the rising edge of clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/nket_pkg.sv
// Package for the name keyed entry table: beat types, op codes and defaults.
`default_nettype none
package nket_pkg;

  localparam int NKET_ENTRIES    = 16;
  localparam int NKET_NAME_CHARS = 8;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 4;
  localparam int SECTOR_W = 12;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    name_key;
    logic [SLOT_W-1:0]   slot_index;
    logic [SECTOR_W-1:0] sector_in;
    logic [KIND_W-1:0]   kind_in;
  } nket_req_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   slot_out;
    logic [SECTOR_W-1:0] sector_out;
    logic [KIND_W-1:0]   kind_out;
    logic [KEY_W-1:0]    name_out;
    logic [COUNT_W-1:0]  valid_count;
  } nket_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/name_keyed_entry_table_unit.sv
// Name keyed entry table: slot memory, valid bits and the scan sequencer.
//
// Usage: present a request beat on req and raise start while busy is low; the
// beat is taken at that clock edge and busy rises. The op field selects find,
// add, remove by name, or read by index. The name key is cut at its first zero
// byte (and after NAME_CHARS bytes) before it is compared or stored.
// Exactly one result beat per request comes back on rsp, marked by done for a
// single cycle; the receiver cannot stall, so it must take the beat then.
// Find, add and remove walk the slot memory one slot per cycle through a single
// read port and one name comparator, stopping at the first hit. A miss or a
// successful add walks every slot before done, and the next beat can be
// accepted in the cycle done is high. Read by index does one memory read.
// Every result carries the valid entry count after the operation.
// Reset (rst, synchronous) clears all valid bits and the count; the slot memory
// itself is not cleared, since a slot's data is only used while it is valid.
`default_nettype none
module name_keyed_entry_table_unit
  import nket_pkg::*;
#(
  parameter int ENTRIES    = NKET_ENTRIES,
  parameter int NAME_CHARS = NKET_NAME_CHARS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire nket_req_t req,
  output logic           done,
  output nket_rsp_t      rsp
);

`include "assert_macros.svh"

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int NAME_W = 8 * NAME_CHARS;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_READ = 3'b100
  } state_t;

  typedef struct packed {
    logic [NAME_W-1:0]   name;
    logic [SECTOR_W-1:0] sector;
    logic [KIND_W-1:0]   kind;
  } entry_t;

  // Keep bytes up to the first zero byte, within NAME_CHARS.
  function automatic logic [NAME_W-1:0] canon_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i >= NAME_CHARS || k[8*i +: 8] == 8'd0) live = 1'b0;
      if (live) r[8*i +: 8] = k[8*i +: 8];
    end
    return NAME_W'(r);
  endfunction

  state_t              state, state_next;
  logic [ENTRIES-1:0]  valid;
  logic [CNT_W-1:0]    count, count_next;
  entry_t              mem [ENTRIES];
  entry_t              rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    cmp_ptr;
  logic [IDX_W-1:0]    scan_ptr;
  logic [OP_W-1:0]     op_q;
  logic [NAME_W-1:0]   key_q;
  logic [SECTOR_W-1:0] sector_q;
  logic [KIND_W-1:0]   kind_q;
  logic                idx_ok_q;
  logic                free_found;
  logic [IDX_W-1:0]    first_free;

  logic                accept;
  logic                hit, last, free_now;
  logic [IDX_W-1:0]    free_sel;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic                set_v, clr_v;
  logic [IDX_W-1:0]    v_addr;
  logic                finish;
  nket_rsp_t           rsp_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign hit      = valid[cmp_ptr] && (rd_data.name == key_q);
  assign last     = (cmp_ptr == LAST_SLOT);
  assign free_now = !valid[cmp_ptr];
  assign free_sel = free_found ? first_free : cmp_ptr;

  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = (req.op == OP_READ) ? IDX_W'(req.slot_index) : '0;
    end else begin
      rd_addr = scan_ptr;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    finish     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = free_sel;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    v_addr     = cmp_ptr;
    rsp_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = (req.op == OP_READ) ? S_READ : S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          finish = 1'b1;
          if (op_q != OP_ADD) begin
            rsp_next.ok         = 1'b1;
            rsp_next.slot_out   = SLOT_W'(cmp_ptr);
            rsp_next.sector_out = rd_data.sector;
            rsp_next.kind_out   = rd_data.kind;
          end
          if (op_q == OP_REMOVE) begin
            clr_v      = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end else if (last) begin
          finish = 1'b1;
          if (op_q == OP_ADD && (free_found || free_now)) begin
            wr_en               = 1'b1;
            set_v               = 1'b1;
            v_addr              = free_sel;
            count_next          = count + CNT_W'(1);
            rsp_next.ok         = 1'b1;
            rsp_next.slot_out   = SLOT_W'(free_sel);
            rsp_next.sector_out = sector_q;
            rsp_next.kind_out   = kind_q;
          end
        end
      end
      S_READ: begin
        finish = 1'b1;
        if (idx_ok_q && valid[cmp_ptr]) begin
          rsp_next.ok         = 1'b1;
          rsp_next.slot_out   = SLOT_W'(cmp_ptr);
          rsp_next.sector_out = rd_data.sector;
          rsp_next.kind_out   = rd_data.kind;
          rsp_next.name_out   = KEY_W'(rd_data.name);
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (finish) state_next = S_IDLE;
    rsp_next.valid_count = COUNT_W'(count_next);
  end

  // Slot memory: one read port with registered data, one write port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= '{name: key_q, sector: sector_q, kind: kind_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
      if (set_v) valid[v_addr] <= 1'b1;
      if (clr_v) valid[v_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmp_ptr <= rd_addr;
    if (finish) rsp <= rsp_next;
    if (accept) begin
      op_q       <= req.op;
      key_q      <= canon_key(req.name_key);
      sector_q   <= req.sector_in;
      kind_q     <= req.kind_in;
      idx_ok_q   <= (32'(req.slot_index) < ENTRIES);
      scan_ptr   <= (ENTRIES > 1) ? IDX_W'(1) : '0;
      free_found <= 1'b0;
    end else if (state == S_SCAN) begin
      // Advance the read address ahead of the compare; hold at the last slot.
      if (scan_ptr != LAST_SLOT) scan_ptr <= scan_ptr + IDX_W'(1);
      if (free_now && !free_found) begin
        free_found <= 1'b1;
        first_free <= cmp_ptr;
      end
    end
  end

  `ASSERT_IMPL(a_count_matches_valid, 1'b1, count == CNT_W'($countones(valid)))
  `ASSERT_IMPL(a_done_idle, done, !busy)
  `ASSERT_NEXT(a_accept_busy, accept, busy)
  `ASSERT_IMPL(a_fail_zero, done && !rsp.ok, rsp.slot_out == '0 && rsp.sector_out == '0 && rsp.kind_out == '0 && rsp.name_out == '0)

endmodule
`default_nettype wire

>>> tb/sv/tb_name_keyed_entry_table_unit.sv
// Testbench for name_keyed_entry_table_unit: predicts each reply and checks it on done.
`default_nettype none
module tb_name_keyed_entry_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import nket_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int POOL_SIZE   = 24;
  localparam int RANDOM_ITEMS = 740;

  // Tracks the table contents and the replies still owed by the block.
  class nket_table_tracker;
    logic                slot_valid [NKET_ENTRIES];
    logic [KEY_W-1:0]    slot_name  [NKET_ENTRIES];
    logic [SECTOR_W-1:0] slot_sector[NKET_ENTRIES];
    logic [KIND_W-1:0]   slot_kind  [NKET_ENTRIES];
    int                  live_entries;
    nket_rsp_t           replies_due[$];
    int                  errors;
    int                  op_seen[4];
    int                  op_ok[4];
    int                  full_refusals;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      live_entries = 0;
      errors = 0;
      full_refusals = 0;
      foreach (op_seen[i]) begin
        op_seen[i] = 0;
        op_ok[i] = 0;
      end
    endfunction

    function int lookup(logic [KEY_W-1:0] key);
      for (int i = 0; i < NKET_ENTRIES; i++)
        if (slot_valid[i] && slot_name[i] == key) return i;
      return -1;
    endfunction

    // Work out the reply for an accepted request beat and update the table.
    function void take_request(nket_req_t r);
      nket_rsp_t        e;
      logic [KEY_W-1:0] key;
      int               hit;
      e = '0;
      key = '0;
      // Cut the key at its first zero byte.
      for (int b = 0; b < NKET_NAME_CHARS; b++) begin
        if (r.name_key[8*b +: 8] == 8'h00) break;
        key[8*b +: 8] = r.name_key[8*b +: 8];
      end
      hit = lookup(key);
      case (r.op)
        OP_FIND: begin
          if (hit >= 0) begin
            e.ok = 1'b1;
            e.slot_out = SLOT_W'(hit);
            e.sector_out = slot_sector[hit];
            e.kind_out = slot_kind[hit];
          end
        end
        OP_ADD: begin
          if (hit < 0) begin
            for (int i = 0; i < NKET_ENTRIES; i++) begin
              if (!slot_valid[i]) begin
                slot_valid[i] = 1'b1;
                slot_name[i] = key;
                slot_sector[i] = r.sector_in;
                slot_kind[i] = r.kind_in;
                live_entries++;
                e.ok = 1'b1;
                e.slot_out = SLOT_W'(i);
                e.sector_out = r.sector_in;
                e.kind_out = r.kind_in;
                break;
              end
            end
            if (!e.ok) full_refusals++;
          end
        end
        OP_REMOVE: begin
          if (hit >= 0) begin
            slot_valid[hit] = 1'b0;
            live_entries--;
            e.ok = 1'b1;
            e.slot_out = SLOT_W'(hit);
            e.sector_out = slot_sector[hit];
            e.kind_out = slot_kind[hit];
          end
        end
        default: begin
          if (slot_valid[r.slot_index]) begin
            e.ok = 1'b1;
            e.slot_out = r.slot_index;
            e.sector_out = slot_sector[r.slot_index];
            e.kind_out = slot_kind[r.slot_index];
            e.name_out = slot_name[r.slot_index];
          end
        end
      endcase
      e.valid_count = COUNT_W'(live_entries);
      op_seen[r.op]++;
      if (e.ok) op_ok[r.op]++;
      replies_due.push_back(e);
    endfunction

    function void report(string field, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] act_v);
      $display("%0t: %s expected %h, got %h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    // Compare a reply beat with the oldest prediction.
    function void check_reply(nket_rsp_t got);
      nket_rsp_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none pending, got %h", $time, got);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (got.ok !== e.ok) report("ok", KEY_W'(e.ok), KEY_W'(got.ok));
      if (got.slot_out !== e.slot_out)
        report("slot_out", KEY_W'(e.slot_out), KEY_W'(got.slot_out));
      if (got.sector_out !== e.sector_out)
        report("sector_out", KEY_W'(e.sector_out), KEY_W'(got.sector_out));
      if (got.kind_out !== e.kind_out)
        report("kind_out", KEY_W'(e.kind_out), KEY_W'(got.kind_out));
      if (got.name_out !== e.name_out) report("name_out", e.name_out, got.name_out);
      if (got.valid_count !== e.valid_count)
        report("valid_count", KEY_W'(e.valid_count), KEY_W'(got.valid_count));
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  nket_req_t req;
  logic      done;
  nket_rsp_t rsp;

  nket_table_tracker tracker;
  logic [KEY_W-1:0]  name_pool[POOL_SIZE];
  int                name_len[POOL_SIZE];
  bit                gaps_on;
  int                cycles;

  name_keyed_entry_table_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) tracker.check_reply(rsp);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies pending", cycles,
               tracker.replies_due.size());
      $display("name_keyed_entry_table_unit: mismatch");
      $finish;
    end
  end

  function automatic nket_req_t noise_req();
    nket_req_t r;
    r.op = OP_W'($urandom_range(3));
    r.name_key = {$urandom, $urandom};
    r.slot_index = SLOT_W'($urandom_range(15));
    r.sector_in = SECTOR_W'($urandom_range(4095));
    r.kind_in = KIND_W'($urandom_range(3));
    return r;
  endfunction

  // Mostly names from the pool, some padded with junk past the terminator.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int               p;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 80) begin
      p = $urandom_range(POOL_SIZE - 1);
      k = name_pool[p];
      if (name_len[p] < 8 && $urandom_range(2) == 0) begin
        k = k | ({$urandom, $urandom} << (8 * (name_len[p] + 1)));
      end
    end else if (roll < 92) begin
      k = {$urandom, $urandom};
    end else begin
      k = KEY_W'($urandom_range(255));
    end
    return k;
  endfunction

  task automatic drive_idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      req = noise_req();
    end
  endtask

  // Hold off until every predicted reply has been checked.
  task automatic wait_drained();
    while (tracker.replies_due.size() != 0) @(posedge clk);
  endtask

  // Present one request beat and hold it until the block takes it.
  task automatic issue(input nket_req_t r);
    if (gaps_on && $urandom_range(99) < 11)
      drive_idle($urandom_range(1, 20));
    @(negedge clk);
    start = 1'b1;
    req = r;
    do @(posedge clk); while (busy);
    tracker.take_request(r);
  endtask

  task automatic issue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic [SLOT_W-1:0] idx, input logic [SECTOR_W-1:0] sec,
                          input logic [KIND_W-1:0] kind);
    nket_req_t r;
    r.op = op;
    r.name_key = key;
    r.slot_index = idx;
    r.sector_in = sec;
    r.kind_in = kind;
    issue(r);
  endtask

  initial begin
    nket_req_t   r;
    int          add_w;
    int          rem_w;
    int          roll;
    logic [63:0] k;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cycles = 0;
    gaps_on = 1'b1;
    tracker = new();
    foreach (name_pool[i]) begin
      name_len[i] = $urandom_range(1, 8);
      k = '0;
      for (int b = 0; b < name_len[i]; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
      name_pool[i] = k;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, extreme keys and fields, duplicates, refill order.
    issue_op(OP_FIND, name_pool[0], 0, 0, 0);
    issue_op(OP_READ, 0, 0, 0, 0);
    issue_op(OP_REMOVE, name_pool[0], 0, 0, 0);
    issue_op(OP_ADD, '1, 4'hf, 12'hfff, 2'd3);
    issue_op(OP_ADD, '0, 0, 12'h000, 2'd0);
    issue_op(OP_ADD, name_pool[0], 0, SECTOR_W'($urandom_range(4095)), 2'd1);
    issue_op(OP_ADD, name_pool[0] | (64'hA5 << (8 * name_len[0]) + 8), 0, 1, 2'd2);
    issue_op(OP_ADD, name_pool[1], 0, SECTOR_W'($urandom_range(4095)), 2'd2);
    issue_op(OP_FIND, '1, 0, 0, 0);
    issue_op(OP_FIND, 64'hFFFF_FFFF_FFFF_FF00, 0, 0, 0);
    issue_op(OP_FIND, name_pool[1], 0, 0, 0);
    issue_op(OP_READ, 0, 0, 0, 0);
    issue_op(OP_READ, 0, 1, 0, 0);
    issue_op(OP_READ, 0, 3, 0, 0);
    issue_op(OP_READ, 0, 4'hf, 0, 0);
    issue_op(OP_REMOVE, '0, 0, 0, 0);
    issue_op(OP_REMOVE, '0, 0, 0, 0);
    issue_op(OP_FIND, '0, 0, 0, 0);
    issue_op(OP_ADD, name_pool[2], 0, SECTOR_W'($urandom_range(4095)), 2'd1);
    issue_op(OP_READ, 0, 1, 0, 0);
    issue_op(OP_REMOVE, '1, 0, 0, 0);

    // Random: fill-heavy, then balanced, then drain-heavy, then balanced again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 300 && n < 450);
      if (n < 150) begin
        add_w = 55; rem_w = 10;
      end else if (n < 400) begin
        add_w = 35; rem_w = 25;
      end else if (n < 550) begin
        add_w = 15; rem_w = 50;
      end else begin
        add_w = 40; rem_w = 20;
      end
      if (n == 370) begin
        // Let the block drain completely before going on.
        drive_idle(1);
        wait_drained();
      end
      r = noise_req();
      r.name_key = pick_key();
      roll = $urandom_range(99);
      if (roll < add_w) r.op = OP_ADD;
      else if (roll < add_w + rem_w) r.op = OP_REMOVE;
      else if (roll < add_w + rem_w + 20) r.op = OP_READ;
      else r.op = OP_FIND;
      issue(r);
    end

    drive_idle(1);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("requests find/add/remove/read: %0d/%0d/%0d/%0d, successes %0d/%0d/%0d/%0d",
             tracker.op_seen[OP_FIND], tracker.op_seen[OP_ADD],
             tracker.op_seen[OP_REMOVE], tracker.op_seen[OP_READ],
             tracker.op_ok[OP_FIND], tracker.op_ok[OP_ADD],
             tracker.op_ok[OP_REMOVE], tracker.op_ok[OP_READ]);
    $display("adds refused on a full table: %0d, errors: %0d",
             tracker.full_refusals, tracker.errors);
    if (tracker.errors == 0) begin
      $display("name_keyed_entry_table_unit: match");
    end else begin
      $display("name_keyed_entry_table_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> name_keyed_entry_table_unit.f
+incdir+rtl/core
rtl/core/nket_pkg.sv
rtl/core/name_keyed_entry_table_unit.sv
tb/sv/tb_name_keyed_entry_table_unit.sv
